@@ rtl/glzw_pkg.sv @@
// Shared types, constants and helpers for the GIF LZW decoder.
package glzw_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int BUFFER_BITS_DEF   = 24;
    localparam logic [3:0] MCS_RESET = 4'd8;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pixel_index;
        logic       last_of_string;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_PIXEL   = 3'd0,
        ST_NONE    = 3'd1,
        ST_NEED    = 3'd2,
        ST_ENDED   = 3'd3,
        ST_INVALID = 3'd4,
        ST_REJECT  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_PUSH,
        OP_POP,
        OP_CONS_END,
        OP_CONS_CLEAR,
        OP_CONS_FIRST,
        OP_CONS_ERR,
        OP_START_WALK,
        OP_START_KWK,
        OP_WALK_RD,
        OP_WALK_STEP,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    res_load;
        t_status res_status;
        logic    res_pixel;
    } t_dp_cmd;

    typedef struct packed {
        logic push_full;
        logic stack_nonempty;
        logic err;
        logic ended;
        logic short_bits;
        logic code_end;
        logic code_clear;
        logic have_prev;
        logic code_root;
        logic code_known;
        logic code_kwk;
        logic walk_root;
    } t_dp_stat;

    // min code size clamped to 2..8
    function automatic logic [3:0] eff_min(input logic [3:0] mcs);
        logic [3:0] r;
        if (mcs < 4'd2) begin
            r = 4'd2;
        end else if (mcs > 4'd8) begin
            r = 4'd8;
        end else begin
            r = mcs;
        end
        return r;
    endfunction

endpackage

@@ rtl/glzw_ctrl.sv @@
// Control state machine of the GIF LZW decoder.
module glzw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  glzw_pkg::t_dp_stat i_stat,
    output glzw_pkg::t_dp_cmd  o_cmd
);
    import glzw_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_POPOUT, S_WALK, S_WAIT} t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    w_accept;
    t_dp_cmd w_cmd;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall))
                         || i_cfg_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    always_comb begin
        n_state              = r_state;
        w_cmd.op             = OP_NONE;
        w_cmd.res_load       = 1'b0;
        w_cmd.res_status     = ST_NONE;
        w_cmd.res_pixel      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    w_cmd.op = OP_INIT;
                end else if (w_accept) begin
                    w_cmd.res_load = 1'b1;
                    if (!i_in_cmd) begin
                        if (i_stat.push_full) begin
                            w_cmd.res_status = ST_REJECT;
                        end else begin
                            w_cmd.op = OP_PUSH;
                        end
                    end else if (i_stat.stack_nonempty) begin
                        w_cmd.op       = OP_POP;
                        w_cmd.res_load = 1'b0;
                        n_state        = S_POPOUT;
                    end else if (i_stat.err) begin
                        w_cmd.res_status = ST_INVALID;
                    end else if (i_stat.ended) begin
                        w_cmd.res_status = ST_ENDED;
                    end else if (i_stat.short_bits) begin
                        w_cmd.res_status = ST_NEED;
                    end else if (i_stat.code_end) begin
                        w_cmd.op         = OP_CONS_END;
                        w_cmd.res_status = ST_ENDED;
                    end else if (i_stat.code_clear) begin
                        w_cmd.op = OP_CONS_CLEAR;
                    end else if (!i_stat.have_prev) begin
                        if (i_stat.code_root) begin
                            w_cmd.op = OP_CONS_FIRST;
                        end else begin
                            w_cmd.op         = OP_CONS_ERR;
                            w_cmd.res_status = ST_INVALID;
                        end
                    end else if (i_stat.code_known) begin
                        w_cmd.op       = OP_START_WALK;
                        w_cmd.res_load = 1'b0;
                        n_state        = S_WALK;
                    end else if (i_stat.code_kwk) begin
                        w_cmd.op       = OP_START_KWK;
                        w_cmd.res_load = 1'b0;
                        n_state        = S_WALK;
                    end else begin
                        w_cmd.op         = OP_CONS_ERR;
                        w_cmd.res_status = ST_INVALID;
                    end
                end
            end
            S_POPOUT: begin
                w_cmd.res_load   = 1'b1;
                w_cmd.res_status = ST_PIXEL;
                w_cmd.res_pixel  = 1'b1;
                n_state          = S_IDLE;
            end
            S_WALK: begin
                if (i_stat.walk_root) begin
                    w_cmd.op       = OP_FINISH;
                    w_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    w_cmd.op = OP_WALK_RD;
                    n_state  = S_WAIT;
                end
            end
            S_WAIT: begin
                w_cmd.op = OP_WALK_STEP;
                n_state  = S_WALK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a result is only produced when the output slot can take it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.res_load && r_state != S_IDLE) |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrites a pending item");
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    a_pop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POPOUT) |=> (r_out_valid && r_state == S_IDLE))
        else $error("pop result missing");

endmodule

@@ rtl/glzw_dp.sv @@
// Datapath of the GIF LZW decoder: bit buffer, dictionary, string stack.
module glzw_dp #(
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
    parameter int BUFFER_BITS   = glzw_pkg::BUFFER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  glzw_pkg::t_in_item  i_in_data,
    input  logic [3:0]          i_cfg_data,
    input  glzw_pkg::t_dp_cmd   i_cmd,
    output glzw_pkg::t_dp_stat  o_stat,
    output glzw_pkg::t_out_item o_out_data
);
    import glzw_pkg::*;

    localparam int MCB   = MAX_CODE_BITS;
    localparam int BB    = BUFFER_BITS;
    localparam int TABLE = 1 << MCB;
    localparam int BCW   = $clog2(BB + 1);
    localparam int WW    = $clog2(MCB + 1);

    logic [MCB-1:0] m_pre [TABLE];
    logic [7:0]     m_suf [TABLE];
    logic [7:0]     m_stk [TABLE];

    logic [3:0]     r_mcs;
    logic [BB-1:0]  r_buf, n_buf;
    logic [BCW-1:0] r_bcnt, n_bcnt;
    logic [WW-1:0]  r_width, n_width;
    logic [MCB:0]   r_nfc, n_nfc;
    logic [MCB-1:0] r_prev, n_prev;
    logic           r_have, n_have;
    logic [7:0]     r_pfirst, n_pfirst;
    logic           r_ended, n_ended;
    logic           r_err, n_err;
    logic [MCB:0]   r_scnt, n_scnt;
    logic [MCB-1:0] r_c, n_c;
    logic [MCB-1:0] r_code, n_code;
    logic           r_kwk, n_kwk;
    logic [MCB-1:0] r_pre_rd;
    logic [7:0]     r_suf_rd;
    logic [7:0]     r_stk_rd;
    t_out_item      r_out;

    logic [3:0]     w_eff;
    logic [MCB:0]   w_clear;
    logic [BB-1:0]  w_mask;
    logic [MCB-1:0] w_code;
    logic           w_push;
    logic [7:0]     w_push_data;
    logic           w_tbl_we;
    logic [7:0]     w_first;
    logic [MCB:0]   w_nfc_inc;
    logic [BCW:0]   w_bcnt_plus;

    assign w_eff       = eff_min(r_mcs);
    assign w_clear     = (MCB+1)'(1) << w_eff;
    assign w_mask      = (BB'(1) << r_width) - BB'(1);
    assign w_code      = MCB'(r_buf & w_mask);
    assign w_bcnt_plus = {1'b0, r_bcnt} + (BCW+1)'(8);
    assign w_first     = r_kwk ? r_pfirst : r_c[7:0];
    assign w_nfc_inc   = r_nfc + (MCB+1)'(1);

    assign o_stat.push_full      = (w_bcnt_plus > (BCW+1)'(BB));
    assign o_stat.stack_nonempty = (r_scnt != '0);
    assign o_stat.err            = r_err;
    assign o_stat.ended          = r_ended;
    assign o_stat.short_bits     = (int'(r_bcnt) < int'(r_width));
    assign o_stat.code_end       = ({1'b0, w_code} == w_clear + (MCB+1)'(1));
    assign o_stat.code_clear     = ({1'b0, w_code} == w_clear);
    assign o_stat.have_prev      = r_have;
    assign o_stat.code_root      = ({1'b0, w_code} < w_clear);
    assign o_stat.code_known     = ({1'b0, w_code} < r_nfc);
    assign o_stat.code_kwk       = ({1'b0, w_code} == r_nfc) && !r_nfc[MCB];
    assign o_stat.walk_root      = ({1'b0, r_c} < w_clear);
    assign o_out_data            = r_out;

    always_comb begin
        n_buf       = r_buf;
        n_bcnt      = r_bcnt;
        n_width     = r_width;
        n_nfc       = r_nfc;
        n_prev      = r_prev;
        n_have      = r_have;
        n_pfirst    = r_pfirst;
        n_ended     = r_ended;
        n_err       = r_err;
        n_scnt      = r_scnt;
        n_c         = r_c;
        n_code      = r_code;
        n_kwk       = r_kwk;
        w_push      = 1'b0;
        w_push_data = '0;
        w_tbl_we    = 1'b0;
        case (i_cmd.op)
            OP_PUSH: begin
                n_buf  = r_buf | (BB'(i_in_data.data_byte) << r_bcnt);
                n_bcnt = r_bcnt + BCW'(8);
            end
            OP_POP: n_scnt = r_scnt - (MCB+1)'(1);
            OP_CONS_END, OP_CONS_CLEAR, OP_CONS_FIRST, OP_CONS_ERR,
            OP_START_WALK, OP_START_KWK: begin
                n_buf  = r_buf >> r_width;
                n_bcnt = r_bcnt - BCW'(r_width);
                case (i_cmd.op)
                    OP_CONS_END: n_ended = 1'b1;
                    OP_CONS_CLEAR: begin
                        n_nfc   = w_clear + (MCB+1)'(2);
                        n_width = WW'(w_eff) + WW'(1);
                        n_have  = 1'b0;
                    end
                    OP_CONS_FIRST: begin
                        w_push      = 1'b1;
                        w_push_data = w_code[7:0];
                        n_prev      = w_code;
                        n_pfirst    = w_code[7:0];
                        n_have      = 1'b1;
                    end
                    OP_CONS_ERR: n_err = 1'b1;
                    OP_START_WALK: begin
                        n_c    = w_code;
                        n_code = w_code;
                        n_kwk  = 1'b0;
                    end
                    default: begin
                        w_push      = 1'b1;
                        w_push_data = r_pfirst;
                        n_c         = r_prev;
                        n_code      = w_code;
                        n_kwk       = 1'b1;
                    end
                endcase
            end
            OP_WALK_STEP: begin
                w_push      = 1'b1;
                w_push_data = r_suf_rd;
                n_c         = r_pre_rd;
            end
            OP_FINISH: begin
                w_push      = 1'b1;
                w_push_data = r_c[7:0];
                if (!r_nfc[MCB]) begin
                    w_tbl_we = 1'b1;
                    n_nfc    = w_nfc_inc;
                    if (w_nfc_inc == ((MCB+1)'(1) << r_width) && r_width < WW'(MCB)) begin
                        n_width = r_width + WW'(1);
                    end
                end
                n_prev   = r_code;
                n_pfirst = w_first;
            end
            default: ;
        endcase
        // stack push saturates at full depth
        if (w_push && !r_scnt[MCB]) begin
            n_scnt = r_scnt + (MCB+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && !r_scnt[MCB]) begin
            m_stk[r_scnt[MCB-1:0]] <= w_push_data;
        end
        if (w_tbl_we) begin
            m_pre[r_nfc[MCB-1:0]] <= r_prev;
            m_suf[r_nfc[MCB-1:0]] <= w_first;
        end
        if (i_cmd.op == OP_WALK_RD) begin
            r_pre_rd <= m_pre[r_c];
            r_suf_rd <= m_suf[r_c];
        end
        if (i_cmd.op == OP_POP) begin
            r_stk_rd <= m_stk[n_scnt[MCB-1:0]];
        end
        if (i_cmd.res_load) begin
            r_out.status         <= i_cmd.res_status;
            r_out.pixel_index    <= i_cmd.res_pixel ? r_stk_rd : 8'd0;
            r_out.last_of_string <= i_cmd.res_pixel && (r_scnt == '0);
        end
        r_c    <= n_c;
        r_code <= n_code;
        r_kwk  <= n_kwk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == OP_INIT) begin
            r_mcs    <= !i_rst_n ? MCS_RESET : i_cfg_data;
            r_buf    <= '0;
            r_bcnt   <= '0;
            r_width  <= WW'(eff_min(!i_rst_n ? MCS_RESET : i_cfg_data)) + WW'(1);
            r_nfc    <= ((MCB+1)'(1) << eff_min(!i_rst_n ? MCS_RESET : i_cfg_data))
                        + (MCB+1)'(2);
            r_prev   <= '0;
            r_have   <= 1'b0;
            r_pfirst <= '0;
            r_ended  <= 1'b0;
            r_err    <= 1'b0;
            r_scnt   <= '0;
        end else begin
            r_buf    <= n_buf;
            r_bcnt   <= n_bcnt;
            r_width  <= n_width;
            r_nfc    <= n_nfc;
            r_prev   <= n_prev;
            r_have   <= n_have;
            r_pfirst <= n_pfirst;
            r_ended  <= n_ended;
            r_err    <= n_err;
            r_scnt   <= n_scnt;
        end
    end

    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_bcnt) <= BB)
        else $error("bit count overflow");
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_width) <= MCB && int'(r_width) >= 3)
        else $error("code width out of range");
    a_stack_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_scnt) <= TABLE)
        else $error("stack count overflow");
    a_nfc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_nfc) <= TABLE)
        else $error("next free code overflow");

endmodule

@@ rtl/gif_lzw_decoder_top.sv @@
// Top level of the GIF LZW decoder: controller plus datapath.
// Timing: push and every status-only pull register their result in the cycle after
// accept; a stack pop passes through the stack read register and then the result
// register; a decode steps S_WALK and S_WAIT along the prefix chain, one dictionary
// read and one stack push per chain link. One item at a time; input stalls while busy.
// Reset (synchronous, active low) and a config write restart the decoder as
// after a clear code; dictionary and stack memories are not cleared.
module gif_lzw_decoder_top #(
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
    parameter int BUFFER_BITS   = glzw_pkg::BUFFER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    input  glzw_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    // result item channel
    output logic                o_out_valid,
    output glzw_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    // min code size register write
    input  logic                i_cfg_valid,
    input  logic [3:0]          i_cfg_data,
    output logic                o_cfg_ready
);
    import glzw_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing: accept, decode walk, pop, result handoff
    glzw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // bit buffer, code tables, string stack and result register
    glzw_dp #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .BUFFER_BITS   (BUFFER_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule
